// File: rtl/csd_pkg.sv
// csd_pkg: shared types, constants and codes of the charset detector
// no dependencies
`timescale 1ns / 1ps

package csd_pkg;

    localparam int CNT_W      = 21;
    localparam int MAX_BYTES  = 1048576;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] CFG_FALLBACK = 2'd0;
    localparam logic [1:0] CFG_UTF8_EN  = 2'd1;
    localparam logic [1:0] CFG_MIN_LEN  = 2'd2;

    localparam logic [3:0] V_UTF8    = 4'd0;
    localparam logic [3:0] V_UTF32BE = 4'd1;
    localparam logic [3:0] V_UTF32LE = 4'd2;
    localparam logic [3:0] V_UTF16BE = 4'd3;
    localparam logic [3:0] V_UTF16LE = 4'd4;
    localparam logic [3:0] V_EUCJP   = 4'd5;
    localparam logic [3:0] V_SJIS    = 4'd6;
    localparam logic [3:0] V_BIG5    = 4'd7;
    localparam logic [3:0] V_GBK     = 4'd8;
    localparam logic [3:0] V_EUCKR   = 4'd9;

    // pair scoring commands from front to back
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_PAIR  = 2'd1;  // score generic pair c1,c2
    localparam logic [1:0] OP_SS2   = 2'd2;  // 0x8e special: eucjp +2, special +1
    localparam logic [1:0] OP_SS3   = 2'd3;  // 0x8f special: eucjp +3, special +2

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       mb_inc;  // a lead byte started
        logic       last;    // buffer ends after this command
        logic       final_pair; // score held 0x8f pair at end (same as OP_PAIR)
        logic [CNT_W-1:0] count;
        logic [31:0] head;
        logic        utf8_valid;
    } csd_cmd_t;

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] k);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W-1){1'b0}}, k};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// File: rtl/csd_if.sv
// csd_if: valid/ready channels for input bytes and for verdicts
// depends on nothing
`timescale 1ns / 1ps

interface csd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface csd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] verdict;
    logic       from_fallback;
    modport source (output valid, output verdict, output from_fallback, input ready);
    modport sink (input valid, input verdict, input from_fallback, output ready);
endinterface

// File: rtl/csd_front.sv
// csd_front: accepts bytes, tracks head, length, utf-8 validity and pairing
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_front #(
    parameter int MAX_BYTES = csd_pkg::MAX_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        b,
    input  logic              last,
    output logic              cmd_valid,
    output csd_pkg::csd_cmd_t cmd
);
    localparam int W = csd_pkg::CNT_W;
    localparam logic [W-1:0] CAP = (MAX_BYTES < (2**W - 1)) ?
        W'(MAX_BYTES) : {W{1'b1}};

    logic [W-1:0] count_reg;
    logic [31:0]  head_reg;
    logic [1:0]   phase_reg;
    logic [7:0]   lead_reg, second_reg;
    logic [2:0]   trk_reg;
    logic         ok_reg;

    logic [W-1:0] count_next;
    logic [31:0]  head_next;
    logic [1:0]   phase_next;
    logic [2:0]   trk_next;
    logic         ok_next;
    csd_pkg::csd_cmd_t c;
    logic         bad;

    always_comb
    begin
        head_next = head_reg;
        if (count_reg < W'(4))
        begin
            head_next[8*count_reg[1:0] +: 8] = b;
        end
        count_next = (count_reg < CAP) ? count_reg + W'(1) : count_reg;

        bad = 1'b0;
        trk_next = trk_reg;
        case (trk_reg)
            3'd0:
            begin
                if (b < 8'h80) trk_next = 3'd0;
                else if (csd_pkg::in_rng(b, 8'hC2, 8'hDF)) trk_next = 3'd1;
                else if (b == 8'hE0) trk_next = 3'd4;
                else if (b == 8'hED) trk_next = 3'd5;
                else if (csd_pkg::in_rng(b, 8'hE1, 8'hEF)) trk_next = 3'd2;
                else if (b == 8'hF0) trk_next = 3'd6;
                else if (csd_pkg::in_rng(b, 8'hF1, 8'hF3)) trk_next = 3'd3;
                else if (b == 8'hF4) trk_next = 3'd7;
                else bad = 1'b1;
            end
            3'd1, 3'd2, 3'd3:
            begin
                if (csd_pkg::in_rng(b, 8'h80, 8'hBF)) trk_next = trk_reg - 3'd1;
                else bad = 1'b1;
            end
            3'd4: if (csd_pkg::in_rng(b, 8'hA0, 8'hBF)) trk_next = 3'd1; else bad = 1'b1;
            3'd5: if (csd_pkg::in_rng(b, 8'h80, 8'h9F)) trk_next = 3'd1; else bad = 1'b1;
            3'd6: if (csd_pkg::in_rng(b, 8'h90, 8'hBF)) trk_next = 3'd2; else bad = 1'b1;
            default: if (csd_pkg::in_rng(b, 8'h80, 8'h8F)) trk_next = 3'd2; else bad = 1'b1;
        endcase
        ok_next = ok_reg;
        if (!ok_reg)
        begin
            trk_next = trk_reg;
        end
        else if (bad)
        begin
            ok_next = 1'b0;
            trk_next = 3'd0;
        end

        // pairing
        c = '0;
        c.op = csd_pkg::OP_NONE;
        c.c1 = lead_reg;
        c.c2 = b;
        phase_next = 2'd0;
        if (phase_reg == 2'd1)
        begin
            if (lead_reg == 8'h8E && csd_pkg::in_rng(b, 8'hA1, 8'hDF))
            begin
                c.op = csd_pkg::OP_SS2;
            end
            else if (lead_reg == 8'h8F)
            begin
                phase_next = 2'd2;
            end
            else
            begin
                c.op = csd_pkg::OP_PAIR;
            end
        end
        else if (phase_reg == 2'd2)
        begin
            if (csd_pkg::in_rng(second_reg, 8'hA1, 8'hFE) &&
                csd_pkg::in_rng(b, 8'hA1, 8'hFE))
            begin
                c.op = csd_pkg::OP_SS3;
            end
            else
            begin
                c.op = csd_pkg::OP_PAIR;
                c.c2 = second_reg;
                c.mb_inc = b[7];
                if (b[7]) phase_next = 2'd1;
            end
        end
        else
        begin
            c.mb_inc = b[7];
            if (b[7]) phase_next = 2'd1;
        end
        // a held 0x8f pair at end is scored too
        c.final_pair = last && (phase_next == 2'd2);
        c.last = last;
        c.count = count_next;
        c.head = head_next;
        c.utf8_valid = ok_next && (trk_next == 3'd0);
    end

    assign cmd_valid = in_fire;
    assign cmd = c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg <= '0;
            phase_reg <= 2'd0;
            trk_reg <= 3'd0;
            ok_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            if (last)
            begin
                count_reg <= '0;
                head_reg <= '0;
                phase_reg <= 2'd0;
                trk_reg <= 3'd0;
                ok_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_next;
                head_reg <= head_next;
                phase_reg <= phase_next;
                trk_reg <= trk_next;
                ok_reg <= ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (phase_next == 2'd1) lead_reg <= b;
            if (phase_reg == 2'd1 && phase_next == 2'd2) second_reg <= b;
        end
    end
endmodule

// File: rtl/csd_queue.sv
// csd_queue: small fifo of commands between front and back
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_queue #(
    parameter int DEPTH = csd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  csd_pkg::csd_cmd_t wr_data,
    output logic              full,
    output logic              empty,
    input  logic              rd_en,
    output csd_pkg::csd_cmd_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    csd_pkg::csd_cmd_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd_en) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule

// File: rtl/csd_back.sv
// csd_back: scores pair commands into counters and forms the verdict
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  csd_pkg::csd_cmd_t cmd,
    output logic              cmd_take,
    input  logic [3:0]        fallback_code,
    input  logic              utf8_check_enable,
    input  logic [csd_pkg::CNT_W-1:0] cjk_min_bytes,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [3:0]        verdict,
    output logic              from_fallback
);
    localparam int W = csd_pkg::CNT_W;

    // 0 gbk 1 big5 2 sjis 3 eucjp 4 euckr
    logic [W-1:0] hit_reg [5];
    logic [W-1:0] kana_reg, spec_reg, mb_reg;
    logic [W-1:0] hit_next [5];
    logic [W-1:0] kana_next, spec_next, mb_next;
    logic [W-1:0] h2 [5];
    logic [W-1:0] kana2;

    // decide stage registers
    logic         dec_valid_reg;
    logic [W-1:0] dhit_reg [5];
    logic [W-1:0] dkana_reg, dspec_reg, dmb_reg;
    logic         dcjk_reg, dutf8_reg;
    logic [3:0]   dbom_reg, dfb_reg;
    logic         dbom_hit_reg;

    logic [3:0]   res_verdict_reg;
    logic         res_fb_reg, res_valid_reg;
    logic         out_free, stage_free;
    logic [7:0]   c1, c2;
    logic         do_pair;
    logic         bom_hit;
    logic [3:0]   bom_code;
    logic [7:0]   b0, b1, b2, b3;

    assign out_free   = !res_valid_reg || res_ready;
    assign stage_free = !dec_valid_reg || out_free;
    assign cmd_take   = cmd_valid && (!cmd.last || stage_free);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            hit_next[i] = hit_reg[i];
        end
        kana_next = kana_reg;
        spec_next = spec_reg;
        mb_next = (cmd.mb_inc) ? csd_pkg::sat_add(mb_reg, 2'd1) : mb_reg;
        c1 = cmd.c1;
        c2 = cmd.c2;
        do_pair = (cmd.op == csd_pkg::OP_PAIR);
        case (cmd.op)
            csd_pkg::OP_SS2:
            begin
                hit_next[3] = csd_pkg::sat_add(hit_reg[3], 2'd2);
                spec_next = csd_pkg::sat_add(spec_reg, 2'd1);
            end
            csd_pkg::OP_SS3:
            begin
                hit_next[3] = csd_pkg::sat_add(hit_reg[3], 2'd3);
                spec_next = csd_pkg::sat_add(spec_reg, 2'd2);
            end
            default: ;
        endcase
        if (do_pair)
        begin
            if ((csd_pkg::in_rng(c1, 8'h81, 8'h9F) || csd_pkg::in_rng(c1, 8'hE0, 8'hFC)) &&
                (csd_pkg::in_rng(c2, 8'h40, 8'h7E) || csd_pkg::in_rng(c2, 8'h80, 8'hFC)))
            begin
                hit_next[2] = csd_pkg::sat_add(hit_reg[2], 2'd2);
                if (c1 == 8'h82 || c1 == 8'h83) kana_next = csd_pkg::sat_add(kana_reg, 2'd1);
            end
            if (csd_pkg::in_rng(c1, 8'h81, 8'hFE) && csd_pkg::in_rng(c2, 8'h40, 8'hFE) &&
                c2 != 8'h7F)
                hit_next[0] = csd_pkg::sat_add(hit_reg[0], 2'd2);
            if (csd_pkg::in_rng(c1, 8'h81, 8'hFE) &&
                (csd_pkg::in_rng(c2, 8'h40, 8'h7E) || csd_pkg::in_rng(c2, 8'hA1, 8'hFE)))
                hit_next[1] = csd_pkg::sat_add(hit_reg[1], 2'd2);
            if (csd_pkg::in_rng(c1, 8'hA1, 8'hFE) && csd_pkg::in_rng(c2, 8'hA1, 8'hFE))
            begin
                hit_next[3] = csd_pkg::sat_add(hit_reg[3], 2'd2);
                hit_next[4] = csd_pkg::sat_add(hit_reg[4], 2'd2);
            end
        end
        // held 0x8f lead with its second byte at buffer end: c1 8f, c2 = second
        for (int i = 0; i < 5; i++)
        begin
            h2[i] = hit_next[i];
        end
        kana2 = kana_next;
        if (cmd.final_pair)
        begin
            // c1 is 0x8f here: sjis, gbk and big5 can score, never kana or the euc pair
            if (csd_pkg::in_rng(c2, 8'h40, 8'h7E) || csd_pkg::in_rng(c2, 8'h80, 8'hFC))
                h2[2] = csd_pkg::sat_add(hit_next[2], 2'd2);
            if (csd_pkg::in_rng(c2, 8'h40, 8'hFE) && c2 != 8'h7F)
                h2[0] = csd_pkg::sat_add(hit_next[0], 2'd2);
            if (csd_pkg::in_rng(c2, 8'h40, 8'h7E) || csd_pkg::in_rng(c2, 8'hA1, 8'hFE))
                h2[1] = csd_pkg::sat_add(hit_next[1], 2'd2);
        end

        b0 = cmd.head[7:0];
        b1 = cmd.head[15:8];
        b2 = cmd.head[23:16];
        b3 = cmd.head[31:24];
        bom_hit = 1'b1;
        bom_code = csd_pkg::V_UTF8;
        if (cmd.count >= W'(4) && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE && b3 == 8'hFF)
            bom_code = csd_pkg::V_UTF32BE;
        else if (cmd.count >= W'(4) && b0 == 8'hFF && b1 == 8'hFE && b2 == 8'h00 &&
                 b3 == 8'h00)
            bom_code = csd_pkg::V_UTF32LE;
        else if (cmd.count >= W'(3) && b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF)
            bom_code = csd_pkg::V_UTF8;
        else if (cmd.count >= W'(2) && b0 == 8'hFE && b1 == 8'hFF)
            bom_code = csd_pkg::V_UTF16BE;
        else if (cmd.count >= W'(2) && b0 == 8'hFF && b1 == 8'hFE)
            bom_code = csd_pkg::V_UTF16LE;
        else
            bom_hit = 1'b0;
    end

    // note: the final-pair path uses c2 as the held second byte; the front
    // sends c2 = current byte there, so the front supplies that in cmd.c2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                hit_reg[i] <= '0;
            end
            kana_reg <= '0;
            spec_reg <= '0;
            mb_reg <= '0;
            dec_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                if (cmd.last)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        hit_reg[i] <= '0;
                    end
                    kana_reg <= '0;
                    spec_reg <= '0;
                    mb_reg <= '0;
                end
                else
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        hit_reg[i] <= hit_next[i];
                    end
                    kana_reg <= kana_next;
                    spec_reg <= spec_next;
                    mb_reg <= mb_next;
                end
            end
            if (cmd_take && cmd.last)
                dec_valid_reg <= 1'b1;
            else if (out_free)
                dec_valid_reg <= 1'b0;
            if (out_free)
                res_valid_reg <= dec_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.last)
        begin
            for (int i = 0; i < 5; i++)
            begin
                dhit_reg[i] <= h2[i];
            end
            dkana_reg <= kana2;
            dspec_reg <= spec_next;
            dmb_reg <= mb_next;
            dcjk_reg <= (cmd.count >= cjk_min_bytes);
            dutf8_reg <= utf8_check_enable && cmd.utf8_valid;
            dbom_hit_reg <= bom_hit;
            dbom_reg <= bom_code;
            dfb_reg <= (fallback_code <= csd_pkg::V_EUCKR) ? fallback_code : csd_pkg::V_UTF8;
        end
    end

    logic [3:0] dv;
    logic       dfb;
    always_comb
    begin
        dfb = 1'b0;
        dv = csd_pkg::V_UTF8;
        if (dbom_hit_reg) dv = dbom_reg;
        else if (dutf8_reg) dv = csd_pkg::V_UTF8;
        else if (dcjk_reg && dmb_reg == '0) dv = csd_pkg::V_UTF8;
        else if (dcjk_reg && dspec_reg != '0 && dhit_reg[3] >= dhit_reg[2] &&
                 dhit_reg[3] >= dhit_reg[0]) dv = csd_pkg::V_EUCJP;
        else if (dcjk_reg && dkana_reg != '0 && dhit_reg[2] >= dhit_reg[0])
            dv = csd_pkg::V_SJIS;
        else if (dcjk_reg && dhit_reg[2] > dhit_reg[0] && dhit_reg[2] > dhit_reg[3] &&
                 dhit_reg[2] > dhit_reg[1]) dv = csd_pkg::V_SJIS;
        else if (dcjk_reg && dhit_reg[1] > dhit_reg[0] && dhit_reg[1] > dhit_reg[2])
            dv = csd_pkg::V_BIG5;
        else if (dcjk_reg && dhit_reg[0] != '0 && dhit_reg[0] >= dhit_reg[2] &&
                 dhit_reg[0] >= dhit_reg[3]) dv = csd_pkg::V_GBK;
        else if (dcjk_reg && dhit_reg[4] != '0 && dhit_reg[4] >= dhit_reg[0])
            dv = csd_pkg::V_EUCKR;
        else if (dcjk_reg && dhit_reg[3] != '0) dv = csd_pkg::V_EUCJP;
        else
        begin
            dv = dfb_reg;
            dfb = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && dec_valid_reg)
        begin
            res_verdict_reg <= dv;
            res_fb_reg <= dfb;
        end
    end

    assign res_valid = res_valid_reg;
    assign verdict = res_verdict_reg;
    assign from_fallback = res_fb_reg;
endmodule

// File: rtl/charset_detect_stream.sv
// charset_detect_stream: top level of the byte-stream charset detector
// depends on csd_pkg, csd_if, csd_front, csd_queue, csd_back
`timescale 1ns / 1ps
//
// channel   dir  fields                      transfer when
// in        in   byte_value, last_byte       in.valid && in.ready
// out       out  verdict, from_fallback      out.valid && out.ready
// cfg       in   cfg_we, cfg_index, cfg_data cfg_we high
//
// one byte per cycle is taken while the queue has room; the front part keeps
// head, length, utf-8 state and lead/trail pairing, and hands one scoring
// command per byte through a four-entry queue to the back part, which
// updates the counters. the last byte's command passes from the queue into
// the decide register, then into the output register, where out.valid rises.
// rst_n clears all buffer state and sets the registers to 0, 1, 16.
// a stalled output fills the decide stage, then the queue, then drops ready.

module charset_detect_stream #(
    parameter int MAX_BYTES = csd_pkg::MAX_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    csd_in_if.sink        in,
    csd_out_if.source     out,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [csd_pkg::CNT_W-1:0] cfg_data
);
    logic [3:0] fallback_code_reg;
    logic       utf8_en_reg;
    logic [csd_pkg::CNT_W-1:0] min_bytes_reg;

    logic in_fire;
    logic f_valid;
    csd_pkg::csd_cmd_t f_cmd, q_cmd;
    logic q_full, q_empty, q_take;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_code_reg <= 4'd0;
            utf8_en_reg <= 1'b1;
            min_bytes_reg <= csd_pkg::CNT_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csd_pkg::CFG_FALLBACK: fallback_code_reg <= cfg_data[3:0];
                csd_pkg::CFG_UTF8_EN:  utf8_en_reg <= cfg_data[0];
                csd_pkg::CFG_MIN_LEN:  min_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the queue always has room when ready is shown
    assign in.ready = !q_full;
    assign in_fire = in.valid && in.ready;

    csd_front #(.MAX_BYTES(MAX_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .b(in.byte_value), .last(in.last_byte),
        .cmd_valid(f_valid), .cmd(f_cmd)
    );

    csd_queue #(.DEPTH(csd_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_cmd),
        .full(q_full), .empty(q_empty), .rd_en(q_take), .rd_data(q_cmd)
    );

    csd_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_cmd),
        .cmd_take(q_take), .fallback_code(fallback_code_reg),
        .utf8_check_enable(utf8_en_reg), .cjk_min_bytes(min_bytes_reg),
        .res_valid(out.valid), .res_ready(out.ready),
        .verdict(out.verdict), .from_fallback(out.from_fallback)
    );

    // a verdict never comes from outside the ten codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> (out.verdict <= csd_pkg::V_EUCKR))
        else $error("verdict out of range");

    // no byte is taken while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_fire)
        else $error("transfer into a full queue");

    // a held output stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> (out.valid && $stable(out.verdict)))
        else $error("output changed while stalled");
endmodule

// File: sim/charset_detect_stream_tb.sv
// charset_detect_stream_tb: self-checking testbench of the byte-stream charset detector
// depends on csd_pkg, csd_in_if, csd_out_if and charset_detect_stream from the rtl folder
`timescale 1ns / 1ps

module charset_detect_stream_tb;

    localparam int unsigned SAT_MAX = 2097151;
    localparam int CNT_W = csd_pkg::CNT_W;
    // slots of the per-scheme hit counters
    localparam int HIT_GBK = 0;
    localparam int HIT_BIG5 = 1;
    localparam int HIT_SJIS = 2;
    localparam int HIT_EUCJP = 3;
    localparam int HIT_EUCKR = 4;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [3:0] verdict;
        logic       from_fallback;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;

    csd_in_if in_ch ();
    csd_out_if out_ch ();

    charset_detect_stream uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch.sink),
        .out       (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // bytes waiting to go out, verdicts waiting to come back
    byte_item_t pending_bytes[$];
    verdict_t   verdicts_due[$];
    logic [7:0] build_buf[$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int bytes_sent;
    int verdicts_seen;
    int fallback_seen;
    int buffers_built;

    // shadow of the configuration registers
    logic [3:0]       fallback_reg;
    logic             utf8_en_reg;
    logic [CNT_W-1:0] min_len_reg;

    // shadow of the per-buffer state
    int unsigned length_seen;
    logic [31:0] head_word;
    int unsigned phase;
    logic [7:0]  lead_byte;
    logic [7:0]  second_byte;
    int unsigned hits[5];
    int unsigned kana_count;
    int unsigned special_count;
    int unsigned lead_count;
    int unsigned utf8_state;
    logic        utf8_good;

    function automatic int unsigned bump(input int unsigned a, input int unsigned k);
        return (a + k > SAT_MAX) ? SAT_MAX : a + k;
    endfunction

    function automatic logic within_rng(input logic [7:0] v, input logic [7:0] lo,
                                        input logic [7:0] hi);
        return v >= lo && v <= hi;
    endfunction

    task automatic clear_buffer_state();
        length_seen = 0;
        head_word = '0;
        phase = 0;
        lead_byte = '0;
        second_byte = '0;
        for (int i = 0; i < 5; i++)
        begin
            hits[i] = 0;
        end
        kana_count = 0;
        special_count = 0;
        lead_count = 0;
        utf8_state = 0;
        utf8_good = 1'b1;
    endtask

    // strict rfc 3629 walker: state = continuation bytes still owed, 4..7 are
    // the restricted second-byte cases after e0, ed, f0, f4
    task automatic track_utf8(input logic [7:0] b);
        int unsigned s;
        logic bad;
        s = utf8_state;
        bad = 1'b0;
        if (!utf8_good)
        begin
            return;
        end
        case (s)
            0:
            begin
                if (b < 8'h80) s = 0;
                else if (within_rng(b, 8'hC2, 8'hDF)) s = 1;
                else if (b == 8'hE0) s = 4;
                else if (b == 8'hED) s = 5;
                else if (within_rng(b, 8'hE1, 8'hEF)) s = 2;
                else if (b == 8'hF0) s = 6;
                else if (within_rng(b, 8'hF1, 8'hF3)) s = 3;
                else if (b == 8'hF4) s = 7;
                else bad = 1'b1;
            end
            1, 2, 3: if (within_rng(b, 8'h80, 8'hBF)) s = s - 1; else bad = 1'b1;
            4: if (within_rng(b, 8'hA0, 8'hBF)) s = 1; else bad = 1'b1;
            5: if (within_rng(b, 8'h80, 8'h9F)) s = 1; else bad = 1'b1;
            6: if (within_rng(b, 8'h90, 8'hBF)) s = 2; else bad = 1'b1;
            7: if (within_rng(b, 8'h80, 8'h8F)) s = 2; else bad = 1'b1;
            default: bad = 1'b1;
        endcase
        if (bad)
        begin
            utf8_good = 1'b0;
            s = 0;
        end
        utf8_state = s;
    endtask

    function automatic void score_lead_trail(input logic [7:0] c1, input logic [7:0] c2);
        if ((within_rng(c1, 8'h81, 8'h9F) || within_rng(c1, 8'hE0, 8'hFC)) &&
            (within_rng(c2, 8'h40, 8'h7E) || within_rng(c2, 8'h80, 8'hFC)))
        begin
            hits[HIT_SJIS] = bump(hits[HIT_SJIS], 2);
            if (c1 == 8'h82 || c1 == 8'h83)
            begin
                kana_count = bump(kana_count, 1);
            end
        end
        if (within_rng(c1, 8'h81, 8'hFE) && within_rng(c2, 8'h40, 8'hFE) && c2 != 8'h7F)
        begin
            hits[HIT_GBK] = bump(hits[HIT_GBK], 2);
        end
        if (within_rng(c1, 8'h81, 8'hFE) &&
            (within_rng(c2, 8'h40, 8'h7E) || within_rng(c2, 8'hA1, 8'hFE)))
        begin
            hits[HIT_BIG5] = bump(hits[HIT_BIG5], 2);
        end
        if (within_rng(c1, 8'hA1, 8'hFE) && within_rng(c2, 8'hA1, 8'hFE))
        begin
            hits[HIT_EUCJP] = bump(hits[HIT_EUCJP], 2);
            hits[HIT_EUCKR] = bump(hits[HIT_EUCKR], 2);
        end
    endfunction

    task automatic open_pair(input logic [7:0] b);
        if (b >= 8'h80)
        begin
            lead_count = bump(lead_count, 1);
            lead_byte = b;
            phase = 1;
        end
    endtask

    task automatic pair_bytes(input logic [7:0] b);
        if (phase == 1)
        begin
            phase = 0;
            if (lead_byte == 8'h8E && within_rng(b, 8'hA1, 8'hDF))
            begin
                hits[HIT_EUCJP] = bump(hits[HIT_EUCJP], 2);
                special_count = bump(special_count, 1);
            end
            else if (lead_byte == 8'h8F)
            begin
                second_byte = b;
                phase = 2;
            end
            else
            begin
                score_lead_trail(lead_byte, b);
            end
        end
        else if (phase == 2)
        begin
            phase = 0;
            if (within_rng(second_byte, 8'hA1, 8'hFE) && within_rng(b, 8'hA1, 8'hFE))
            begin
                hits[HIT_EUCJP] = bump(hits[HIT_EUCJP], 3);
                special_count = bump(special_count, 2);
            end
            else
            begin
                score_lead_trail(lead_byte, second_byte);
                open_pair(b);
            end
        end
        else
        begin
            open_pair(b);
        end
    endtask

    // cjk score; returns 0 when nothing wins
    function automatic logic cjk_pick(output logic [3:0] code);
        int unsigned gbk, big5, sjis, eucjp, euckr;
        if (phase == 2)
        begin
            score_lead_trail(lead_byte, second_byte);
        end
        gbk = hits[HIT_GBK];
        big5 = hits[HIT_BIG5];
        sjis = hits[HIT_SJIS];
        eucjp = hits[HIT_EUCJP];
        euckr = hits[HIT_EUCKR];
        code = csd_pkg::V_UTF8;
        if (lead_count == 0) code = csd_pkg::V_UTF8;
        else if (special_count > 0 && eucjp >= sjis && eucjp >= gbk) code = csd_pkg::V_EUCJP;
        else if (kana_count > 0 && sjis >= gbk) code = csd_pkg::V_SJIS;
        else if (sjis > gbk && sjis > eucjp && sjis > big5) code = csd_pkg::V_SJIS;
        else if (big5 > gbk && big5 > sjis) code = csd_pkg::V_BIG5;
        else if (gbk > 0 && gbk >= sjis && gbk >= eucjp) code = csd_pkg::V_GBK;
        else if (euckr > 0 && euckr >= gbk) code = csd_pkg::V_EUCKR;
        else if (eucjp > 0) code = csd_pkg::V_EUCJP;
        else return 1'b0;
        return 1'b1;
    endfunction

    // advance the shadow state by one accepted byte; a last byte queues a verdict
    task automatic take_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        logic decided;
        logic [7:0] h0, h1, h2, h3;
        if (length_seen < 4)
        begin
            head_word = head_word | (32'(b) << (8 * length_seen));
        end
        if (length_seen < csd_pkg::MAX_BYTES)
        begin
            length_seen++;
        end
        track_utf8(b);
        pair_bytes(b);
        if (!last)
        begin
            return;
        end
        {h3, h2, h1, h0} = head_word;
        decided = 1'b1;
        v.from_fallback = 1'b0;
        // byte-order marks need the whole mark inside the buffer
        if (length_seen >= 4 && h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF)
            v.verdict = csd_pkg::V_UTF32BE;
        else if (length_seen >= 4 && h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00)
            v.verdict = csd_pkg::V_UTF32LE;
        else if (length_seen >= 3 && h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF)
            v.verdict = csd_pkg::V_UTF8;
        else if (length_seen >= 2 && h0 == 8'hFE && h1 == 8'hFF)
            v.verdict = csd_pkg::V_UTF16BE;
        else if (length_seen >= 2 && h0 == 8'hFF && h1 == 8'hFE)
            v.verdict = csd_pkg::V_UTF16LE;
        else if (utf8_en_reg && utf8_good && utf8_state == 0)
            v.verdict = csd_pkg::V_UTF8;
        else if (length_seen >= min_len_reg)
            decided = cjk_pick(v.verdict);
        else
            decided = 1'b0;
        if (!decided)
        begin
            // out-of-range fallback codes read as utf-8
            v.verdict = (fallback_reg <= csd_pkg::V_EUCKR) ? fallback_reg : csd_pkg::V_UTF8;
            v.from_fallback = 1'b1;
        end
        verdicts_due.push_back(v);
        clear_buffer_state();
    endtask

    // sender: records the transfer that just happened, then offers the next byte
    always @(posedge clk)
    begin
        byte_item_t nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                take_byte(in_ch.byte_value, in_ch.last_byte);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.byte_value <= nxt.value;
                    in_ch.last_byte <= nxt.last;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each verdict transfer against the oldest expectation
    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                verdicts_seen++;
                if (out_ch.from_fallback)
                begin
                    fallback_seen++;
                end
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected verdict %0d fallback %0b", $time,
                             out_ch.verdict, out_ch.from_fallback);
                    error_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (out_ch.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict mismatch: expected %0d, actual %0d", $time,
                                 want.verdict, out_ch.verdict);
                        error_count++;
                    end
                    if (out_ch.from_fallback !== want.from_fallback)
                    begin
                        $display("%0t: from_fallback mismatch: expected %0b, actual %0b",
                                 $time, want.from_fallback, out_ch.from_fallback);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // register write while the block is idle; the shadow follows it
    task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            csd_pkg::CFG_FALLBACK: fallback_reg = data[3:0];
            csd_pkg::CFG_UTF8_EN:  utf8_en_reg = data[0];
            csd_pkg::CFG_MIN_LEN:  min_len_reg = data;
            default: ;
        endcase
    endtask

    task automatic flush_buffer();
        for (int i = 0; i < build_buf.size(); i++)
        begin
            pending_bytes.push_back({build_buf[i], i == build_buf.size() - 1});
        end
        build_buf.delete();
        buffers_built++;
    endtask

    task automatic push_bytes(input logic [31:0] word, input int count);
        for (int i = 0; i < count; i++)
        begin
            build_buf.push_back(word[8*i +: 8]);
        end
    endtask

    // one random byte in [lo, hi]
    function automatic logic [7:0] rnd8(input logic [7:0] lo, input logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // one well-formed utf-8 code point, edge leads included
    task automatic add_utf8_char();
        case ($urandom_range(7))
            0: push_bytes(32'(rnd8(8'h00, 8'h7F)), 1);
            1: push_bytes(32'({rnd8(8'h80, 8'hBF), rnd8(8'hC2, 8'hDF)}), 2);
            2: push_bytes(32'({rnd8(8'h80, 8'hBF), rnd8(8'hA0, 8'hBF), 8'hE0}), 3);
            3: push_bytes(32'({rnd8(8'h80, 8'hBF), rnd8(8'h80, 8'h9F), 8'hED}), 3);
            4: push_bytes(32'({rnd8(8'h80, 8'hBF), rnd8(8'h80, 8'hBF),
                               rnd8(8'hE1, 8'hEF)}), 3);
            5: push_bytes({rnd8(8'h80, 8'hBF), rnd8(8'h80, 8'hBF),
                           rnd8(8'h90, 8'hBF), 8'hF0}, 4);
            6: push_bytes({rnd8(8'h80, 8'hBF), rnd8(8'h80, 8'hBF),
                           rnd8(8'h80, 8'hBF), rnd8(8'hF1, 8'hF3)}, 4);
            default: push_bytes({rnd8(8'h80, 8'hBF), rnd8(8'h80, 8'hBF),
                                 rnd8(8'h80, 8'h8F), 8'hF4}, 4);
        endcase
    endtask

    // one cjk-flavored unit: plain pairs, single/triple shift specials, kana leads
    task automatic add_cjk_unit();
        case ($urandom_range(6))
            0: push_bytes(32'({rnd8(8'hA1, 8'hFE), rnd8(8'hA1, 8'hFE)}), 2);
            1: push_bytes(32'({rnd8(8'hA1, 8'hDF), 8'h8E}), 2);
            2: push_bytes(32'({rnd8(8'hA1, 8'hFE), rnd8(8'hA1, 8'hFE), 8'h8F}), 3);
            3: push_bytes(32'({rnd8(8'h40, 8'hFC), 7'h41, 1'($urandom_range(1))}), 2);
            4: push_bytes(32'({rnd8(8'h40, 8'hFE), rnd8(8'h81, 8'hFE)}), 2);
            5: push_bytes(32'({rnd8(8'h40, 8'h7E), rnd8(8'h81, 8'h9F)}), 2);
            default: push_bytes(32'(rnd8(8'h20, 8'h7E)), 1);
        endcase
    endtask

    // random buffer; most are well formed, some get noise spliced in
    task automatic add_random_buffer();
        int len;
        int kind;
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 4) : $urandom_range(2, 40);
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            case ($urandom_range(4))
                0: push_bytes(32'hFFFE0000, 4);
                1: push_bytes(32'h0000FEFF, 4);
                2: push_bytes(32'h00BFBBEF, 3);
                3: push_bytes(32'h0000FFFE, 2);
                default: push_bytes(32'h0000FEFF, 2);
            endcase
        end
        while (build_buf.size() < len)
        begin
            if (kind <= 2) add_utf8_char();
            else if (kind <= 6) add_cjk_unit();
            else push_bytes($urandom_range(255), 1);
            if ($urandom_range(19) == 0) push_bytes($urandom_range(255), 1);
        end
        if ($urandom_range(7) == 0) void'(build_buf.pop_back());
        if (build_buf.size() == 0) push_bytes($urandom_range(255), 1);
        flush_buffer();
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || in_ch.valid || verdicts_due.size() > 0)
        begin
            @(posedge clk);
        end
        // verdict path plus margin
        repeat (10) @(posedge clk);
    endtask

    task automatic run_phase(input int n_bytes, input int idle, input int stall);
        int start_count;
        idle_pct = idle;
        stall_pct = stall;
        start_count = bytes_sent + pending_bytes.size();
        while (bytes_sent + pending_bytes.size() - start_count < n_bytes)
        begin
            add_random_buffer();
            // quiet stretches inside a phase
            if ($urandom_range(15) == 0)
            begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        bytes_sent = 0;
        verdicts_seen = 0;
        fallback_seen = 0;
        buffers_built = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = csd_pkg::CFG_FALLBACK;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.byte_value = 8'h00;
        in_ch.last_byte = 1'b0;
        out_ch.ready = 1'b0;
        fallback_reg = 4'd0;
        utf8_en_reg = 1'b1;
        min_len_reg = CNT_W'(16);
        clear_buffer_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every mark, marks cut short, odd endings
        push_bytes(32'h00, 1); flush_buffer();
        push_bytes(32'hFF, 1); flush_buffer();
        push_bytes(32'hFFFE0000, 4); flush_buffer();
        push_bytes(32'h0000FEFF, 4); flush_buffer();
        push_bytes(32'h41BFBBEF, 4); flush_buffer();
        push_bytes(32'hFFFE, 2); flush_buffer();
        push_bytes(32'hFEFF, 2); flush_buffer();
        push_bytes(32'hBBEF, 2); flush_buffer();
        push_bytes(32'h00FEFF, 3); flush_buffer();
        push_bytes(32'h81E3, 2); flush_buffer();
        wait_drained();

        // cjk scoring reachable from length zero, fallback past nine, no utf-8 probe
        write_reg(csd_pkg::CFG_MIN_LEN, '0);
        write_reg(csd_pkg::CFG_UTF8_EN, '0);
        write_reg(csd_pkg::CFG_FALLBACK, CNT_W'(15));
        write_reg(2'd3, CNT_W'(5));
        push_bytes(32'h41, 1); flush_buffer();
        push_bytes(32'hA1A1, 2); flush_buffer();
        push_bytes(32'hA1A18F, 3); flush_buffer();
        push_bytes(32'hA18F, 2); flush_buffer();
        push_bytes(32'h40A18F, 3); flush_buffer();
        push_bytes(32'hB18E, 2); flush_buffer();
        push_bytes(32'h40828E, 3); flush_buffer();
        push_bytes(32'h7F81, 2); flush_buffer();
        push_bytes(32'hA0FE40, 3); flush_buffer();
        push_bytes(32'h4183, 2); flush_buffer();
        push_bytes(32'hC3, 1); flush_buffer();
        wait_drained();
        run_phase(250, 0, 0);

        write_reg(csd_pkg::CFG_FALLBACK, CNT_W'(csd_pkg::V_EUCKR));
        write_reg(csd_pkg::CFG_UTF8_EN, CNT_W'(1));
        write_reg(csd_pkg::CFG_MIN_LEN, {CNT_W{1'b1}});
        run_phase(250, 81, 0);

        write_reg(csd_pkg::CFG_FALLBACK, CNT_W'(10));
        write_reg(csd_pkg::CFG_UTF8_EN, '0);
        write_reg(csd_pkg::CFG_MIN_LEN, CNT_W'(csd_pkg::MAX_BYTES));
        run_phase(150, 0, 81);

        write_reg(csd_pkg::CFG_FALLBACK, CNT_W'(csd_pkg::V_SJIS));
        write_reg(csd_pkg::CFG_MIN_LEN, CNT_W'(6));
        run_phase(250, 0, 81);

        write_reg(csd_pkg::CFG_FALLBACK, CNT_W'(csd_pkg::V_GBK));
        write_reg(csd_pkg::CFG_UTF8_EN, CNT_W'(1));
        write_reg(csd_pkg::CFG_MIN_LEN, CNT_W'(12));
        run_phase(250, 21, 21);

        $display("covered %0d buffers, %0d bytes, %0d verdicts (%0d from fallback)",
                 buffers_built, bytes_sent, verdicts_seen, fallback_seen);
        $display("five register settings, idle and stall mixes, marks, utf-8 and cjk text");
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard
    initial
    begin
        #20ms;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
